/* hdl/form_urlencoded_decoder_macros.svh */
// Assertion macros for the form-urlencoded decoder.
// No dependencies; included by the files that assert.
`ifndef FORM_URLENCODED_DECODER_MACROS_SVH
`define FORM_URLENCODED_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FUD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FUD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/fud_pkg.sv */
// Package for the form-urlencoded decoder: escape phase type, character codes
// and the hex digit helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fud_pkg;

	localparam int CHAR_W = 21;
	localparam int LEN_W  = 16;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_DIGIT1 = 2'd1,
		PH_DIGIT2 = 2'd2,
		PH_ZERO   = 2'd3
	} phase_t;

	localparam logic [CHAR_W-1:0] CH_PERCENT = 21'h25;
	localparam logic [CHAR_W-1:0] CH_PLUS    = 21'h2B;
	localparam logic [CHAR_W-1:0] CH_CR      = 21'h0D;
	localparam logic [CHAR_W-1:0] CH_LF      = 21'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 21'h20;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 21'h30;
	localparam logic [CHAR_W-1:0] CH_UP_D    = 21'h44;
	localparam logic [CHAR_W-1:0] CH_LO_D    = 21'h64;
	localparam logic [CHAR_W-1:0] CH_UP_A    = 21'h41;
	localparam logic [CHAR_W-1:0] CH_LO_A    = 21'h61;

	localparam logic [LEN_W-1:0] LIMIT_RESET = 16'hFFFF;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] b);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (b >= 8'h30 && b <= 8'h39)      h.val = 4'(b - 8'h30);
		else if (b >= 8'h41 && b <= 8'h46) h.val = 4'(b - 8'h37);
		else if (b >= 8'h61 && b <= 8'h66) h.val = 4'(b - 8'h57);
		else                               h.ok  = 1'b0;
		return h;
	endfunction

	function automatic logic [7:0] decode_pair(input logic [7:0] hi_b, input logic [7:0] lo_b);
		hex_t hi;
		hex_t lo;
		hi = hex_value(hi_b);
		lo = hex_value(lo_b);
		if (!hi.ok)      return 8'd0;
		else if (!lo.ok) return {4'd0, hi.val};
		else             return {hi.val, lo.val};
	endfunction

endpackage

`default_nettype wire

/* hdl/form_urlencoded_decoder.sv */
// Form-urlencoded decoder: input register, one-pass decode, three-slot result buffer.
// Depends on fud_pkg and form_urlencoded_decoder_macros.svh.
// The first result of a beat passes through the input register and the result buffer on its way out.
// Throughput: one beat per cycle while the receiver is ready and each beat yields at most one result;
// a beat with more results (at most three) holds the result buffer until they have drained.
// Reset (arst_n low, asynchronous): buffers empty, form state cleared, limit 65535.
`timescale 1ns / 1ps
`default_nettype none
`include "form_urlencoded_decoder_macros.svh"

module form_urlencoded_decoder
	import fud_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [20:0] in_char, [23:21] zero
	input  wire logic                  s_axis_tlast,   // in_last
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [20:0] out_value, [36:21] out_length
	output logic                       m_axis_tuser,   // out_kind
	output logic                       m_axis_tlast,   // out_last
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [LEN_W-1:0]      cfg_data        // output_limit
);

	// input stage
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	// form state
	phase_t            phase_q, phase_d;
	logic              cr_q, cr_d;
	logic [7:0]        digit_q, digit_d;
	logic [LEN_W-1:0]  count_q, count_d;
	logic [LEN_W-1:0]  limit_q;

	// result buffer: slot0 CR, slot1 character, slot2 end marker
	logic [2:0]        res_v_q, res_v_d;
	logic [CHAR_W-1:0] val_q;
	logic [LEN_W-1:0]  len_q;

	logic              under, want1, want2, em1, em2, under2;
	logic [CHAR_W-1:0] val2;
	logic [LEN_W:0]    cnt1, cnt2;
	logic              single, buf_free, load, accept, take;
	logic [2:0]        take_mask;

	assign cfg_ready = 1'b1;
	assign accept    = s_axis_tvalid && s_axis_tready;

	// decode of the registered beat: which results it wants
	always_comb begin
		want1 = 1'b0;
		want2 = 1'b0;
		val2  = CH_SPACE;
		under = count_q < limit_q;
		case (phase_q)
			PH_IDLE: begin
				if (char_s1 == CH_PERCENT) begin
					want1 = cr_q && last_s1;
				end else begin
					want1 = cr_q;
					want2 = 1'b1;
					val2  = (char_s1 == CH_PLUS) ? CH_SPACE : char_s1;
				end
			end
			PH_DIGIT1: begin
				want1 = cr_q && !(char_s1 == CH_ZERO && !last_s1);
			end
			PH_DIGIT2: begin
				want2 = 1'b1;
				val2  = {13'd0, decode_pair(digit_q, char_s1[7:0])};
			end
			PH_ZERO: begin
				if (char_s1 == CH_UP_D || char_s1 == CH_LO_D) begin
					want1 = 1'b0;
				end else if (char_s1 == CH_UP_A || char_s1 == CH_LO_A) begin
					want1 = 1'b1;
					want2 = 1'b1;
					val2  = CH_LF;
				end else begin
					want1 = cr_q;
					want2 = 1'b1;
					val2  = {13'd0, decode_pair(CH_ZERO[7:0], char_s1[7:0])};
				end
			end
			default: begin
				want1 = 1'b0;
			end
		endcase
		// every emit checks the limit against the running count
		em1    = want1 && under;
		cnt1   = {1'b0, count_q} + {{LEN_W{1'b0}}, em1};
		under2 = cnt1 < {1'b0, limit_q};
		em2    = want2 && under && under2;
		cnt2   = cnt1 + {{LEN_W{1'b0}}, em2};
	end

	// next form state
	always_comb begin
		phase_d = phase_q;
		cr_d    = cr_q;
		digit_d = digit_q;
		count_d = count_q;
		if (under) begin
			count_d = cnt2[LEN_W-1:0];
			case (phase_q)
				PH_IDLE: begin
					if (char_s1 == CH_PERCENT) begin
						if (last_s1) cr_d = 1'b0;
						else         phase_d = PH_DIGIT1;
					end else begin
						cr_d = 1'b0;
					end
				end
				PH_DIGIT1: begin
					if (char_s1 == CH_ZERO && !last_s1) begin
						phase_d = PH_ZERO;
					end else begin
						cr_d    = 1'b0;
						digit_d = char_s1[7:0];
						phase_d = PH_DIGIT2;
					end
				end
				PH_DIGIT2: begin
					phase_d = PH_IDLE;
				end
				PH_ZERO: begin
					cr_d    = (char_s1 == CH_UP_D || char_s1 == CH_LO_D);
					phase_d = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		if (last_s1) begin
			phase_d = PH_IDLE;
			cr_d    = 1'b0;
			digit_d = 8'd0;
			count_d = '0;
		end
	end

	// output selection and buffer control
	always_comb begin
		m_axis_tvalid = res_v_q != 3'b000;
		m_axis_tuser  = 1'b0;
		m_axis_tdata  = '0;
		take_mask     = 3'b000;
		if (res_v_q[0]) begin
			m_axis_tdata[CHAR_W-1:0] = CH_CR;
			m_axis_tlast             = !res_v_q[1] && !res_v_q[2];
			take_mask                = 3'b001;
		end else if (res_v_q[1]) begin
			m_axis_tdata[CHAR_W-1:0] = val_q;
			m_axis_tlast             = !res_v_q[2];
			take_mask                = 3'b010;
		end else begin
			m_axis_tdata[CHAR_W+LEN_W-1:CHAR_W] = len_q;
			m_axis_tuser                        = 1'b1;
			m_axis_tlast                        = 1'b1;
			take_mask                           = 3'b100;
		end
		take     = m_axis_tvalid && m_axis_tready;
		single   = (res_v_q & (res_v_q - 3'd1)) == 3'b000;
		buf_free = (res_v_q == 3'b000) || (m_axis_tready && single);
		load     = valid_s1 && buf_free;
		s_axis_tready = !valid_s1 || buf_free;
		if (load)      res_v_d = {last_s1, em2, em1};
		else if (take) res_v_d = res_v_q & ~take_mask;
		else           res_v_d = res_v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_v_q  <= 3'b000;
			phase_q  <= PH_IDLE;
			cr_q     <= 1'b0;
			digit_q  <= 8'd0;
			count_q  <= '0;
			limit_q  <= LIMIT_RESET;
		end else begin
			res_v_q <= res_v_d;
			if (accept)    valid_s1 <= 1'b1;
			else if (load) valid_s1 <= 1'b0;
			if (load) begin
				phase_q <= phase_d;
				cr_q    <= cr_d;
				digit_q <= digit_d;
				count_q <= count_d;
			end
			if (cfg_valid) limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= s_axis_tdata[CHAR_W-1:0];
			last_s1 <= s_axis_tlast;
		end
		if (load) begin
			val_q <= val2;
			len_q <= cnt2[LEN_W-1:0];
		end
	end

	// end marker always closes the beat's results
	`FUD_ASSERT_IMPLY(a_end_is_last, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "end marker without tlast")
	// a final beat leaves the form state cleared
	`FUD_ASSERT_NEXT(a_end_clears, clk, arst_n, load && last_s1, phase_q == PH_IDLE && count_q == '0 && !cr_q, "form state not cleared after final beat")
	// the first escape digit always flushes a pending CR
	`FUD_ASSERT_IMPLY(a_digit2_no_cr, clk, arst_n, phase_q == PH_DIGIT2, !cr_q, "CR pending during second escape digit")

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking bench for form_urlencoded_decoder: directed, output-limit, random
// and backpressure tests against a built-in decode predictor. Uses fud_pkg.
`timescale 1ns / 1ps

module tb_top;
	import fud_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS = 170;
	localparam int NO_IDLE_AFTER = 110;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_UP_F = 8'h46;
	localparam logic [7:0] CH_LO_F = 8'h66;
	localparam logic [CHAR_W-1:0] CH_MAX = 21'h10FFFF;

	typedef struct packed {
		logic              kind;
		logic [CHAR_W-1:0] value;
		logic [LEN_W-1:0]  length;
		logic              last;
	} decoded_beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [LEN_W-1:0]      cfg_data;

	form_urlencoded_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// decoder state as predicted
	logic [LEN_W-1:0] form_limit = LIMIT_RESET;
	logic             cr_held = 1'b0;
	phase_t           esc_phase = PH_IDLE;
	logic [7:0]       esc_digit = 8'd0;
	logic [LEN_W-1:0] form_count = '0;

	decoded_beat_t expected_beats[$];
	decoded_beat_t step_beats[$];

	int  errors = 0;
	int  items_sent = 0;
	int  cycle_count = 0;
	int  rx_hold = 0;
	bit  idle_on = 1'b1;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int hex_nibble(logic [7:0] b);
		if (b >= CH_ZERO[7:0] && b <= CH_NINE) return int'(b - CH_ZERO[7:0]);
		if (b >= CH_UP_A[7:0] && b <= CH_UP_F) return int'(b - CH_UP_A[7:0]) + 10;
		if (b >= CH_LO_A[7:0] && b <= CH_LO_F) return int'(b - CH_LO_A[7:0]) + 10;
		return -1;
	endfunction

	function automatic logic [CHAR_W-1:0] escape_value(logic [7:0] hi_b, logic [7:0] lo_b);
		int hi;
		int lo;
		hi = hex_nibble(hi_b);
		lo = hex_nibble(lo_b);
		if (hi < 0) return '0;
		if (lo < 0) return CHAR_W'(hi);
		return CHAR_W'(hi * 16 + lo);
	endfunction

	function automatic void put_char(logic [CHAR_W-1:0] v);
		if (form_count < form_limit) begin
			step_beats.push_back('{kind: 1'b0, value: v, length: '0, last: 1'b0});
			form_count++;
		end
	endfunction

	function automatic void flush_cr();
		if (cr_held) begin
			put_char(CH_CR);
			cr_held = 1'b0;
		end
	endfunction

	function automatic void predict_decode(logic [CHAR_W-1:0] c, logic last);
		step_beats = {};
		if (form_count < form_limit) begin
			case (esc_phase)
				PH_IDLE: begin
					if (c == CH_PERCENT) begin
						if (last) flush_cr();
						else esc_phase = PH_DIGIT1;
					end else begin
						flush_cr();
						put_char(c == CH_PLUS ? CH_SPACE : c);
					end
				end
				PH_DIGIT1: begin
					if (c == CH_ZERO && !last) begin
						esc_phase = PH_ZERO;
					end else begin
						flush_cr();
						esc_digit = c[7:0];
						esc_phase = PH_DIGIT2;
					end
				end
				PH_DIGIT2: begin
					put_char(escape_value(esc_digit, c[7:0]));
					esc_phase = PH_IDLE;
				end
				default: begin
					// D/A match on the full code point, decode on the low byte
					if (c == CH_UP_D || c == CH_LO_D) begin
						cr_held = 1'b1;
					end else if (c == CH_UP_A || c == CH_LO_A) begin
						put_char(CH_CR);
						cr_held = 1'b0;
						put_char(CH_LF);
					end else begin
						flush_cr();
						put_char(escape_value(CH_ZERO[7:0], c[7:0]));
					end
					esc_phase = PH_IDLE;
				end
			endcase
		end
		if (last) begin
			step_beats.push_back('{kind: 1'b1, value: '0, length: form_count, last: 1'b0});
			cr_held = 1'b0;
			esc_phase = PH_IDLE;
			esc_digit = 8'd0;
			form_count = '0;
		end
		if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
		foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
	endfunction

	// input prediction runs before output checking at each edge
	always @(posedge clk) begin : monitor
		decoded_beat_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("form_urlencoded_decoder: mismatch");
			$finish;
		end
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_decode(s_axis_tdata[CHAR_W-1:0], s_axis_tlast);
			if (cfg_valid && cfg_ready)
				form_limit = cfg_data;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_beats.size() == 0) begin
					$error("output beat with nothing expected: tdata %h", m_axis_tdata);
					errors++;
				end else begin
					want = expected_beats.pop_front();
					if (m_axis_tuser !== want.kind) begin
						$error("out_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata[CHAR_W-1:0] !== want.value) begin
						$error("out_value: expected %h, got %h", want.value,
							m_axis_tdata[CHAR_W-1:0]);
						errors++;
					end
					if (m_axis_tdata[CHAR_W +: LEN_W] !== want.length) begin
						$error("out_length: expected %0d, got %0d", want.length,
							m_axis_tdata[CHAR_W +: LEN_W]);
						errors++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("out_last: expected %0d, got %0d", want.last, m_axis_tlast);
						errors++;
					end
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_axis_tready <= !(idle_on && $urandom_range(99) < 7);
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_char(logic [CHAR_W-1:0] c, logic last);
		while (idle_on && $urandom_range(99) < 7) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W - CHAR_W){1'b0}}, c};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_form(logic [CHAR_W-1:0] chars[$]);
		foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_beats.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(logic [LEN_W-1:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CHAR_W-1:0] rand_hex();
		int v;
		v = $urandom_range(21);
		if (v < 10) return CH_ZERO + CHAR_W'(v);
		if (v < 16) return CH_LO_A + CHAR_W'(v - 10);
		return CH_UP_A + CHAR_W'(v - 16);
	endfunction

	// upper bits set, low byte still a hex digit
	function automatic logic [CHAR_W-1:0] rand_wide_hex();
		logic [CHAR_W-1:0] hx;
		hx = rand_hex();
		return {13'($urandom_range(1, 13'h10FF)), hx[7:0]};
	endfunction

	task automatic add_token(ref logic [CHAR_W-1:0] chars[$]);
		int r;
		r = $urandom_range(99);
		if (r < 35) begin
			chars.push_back(CHAR_W'($urandom_range(8'h20, 8'h7E)));
		end else if (r < 50) begin
			chars.push_back(CH_PERCENT);
			chars.push_back(rand_hex());
			chars.push_back(rand_hex());
		end else if (r < 62) begin
			chars.push_back(CH_PERCENT);
			chars.push_back(CH_ZERO);
			case ($urandom_range(3))
				0: chars.push_back(CH_UP_D);
				1: chars.push_back(CH_LO_D);
				2: chars.push_back(CH_UP_A);
				default: chars.push_back(CH_LO_A);
			endcase
		end else if (r < 68) begin
			chars.push_back(CH_PLUS);
		end else if (r < 78) begin
			chars.push_back(CHAR_W'($urandom_range(0, CH_MAX)));
		end else if (r < 88) begin
			chars.push_back(CH_PERCENT);
			chars.push_back($urandom_range(1) ? rand_wide_hex() : CH_ZERO);
			chars.push_back($urandom_range(1) ? rand_wide_hex() : rand_hex());
		end else begin
			// broken escapes
			chars.push_back(CH_PERCENT);
			case ($urandom_range(2))
				0: ;
				1: chars.push_back(rand_hex());
				default: begin
					chars.push_back(CH_ZERO);
					chars.push_back(CHAR_W'($urandom_range(0, 8'hFF)));
				end
			endcase
		end
	endtask

	task automatic test_directed();
		logic [CHAR_W-1:0] chars[$];
		chars = '{21'h0, CH_MAX, CH_PLUS,
			CH_PERCENT, CH_ZERO, CH_UP_D, "x",
			CH_PERCENT, CH_ZERO, CH_LO_A,
			CH_PERCENT, "G", "1",
			CH_PERCENT, "4", "z",
			CH_PERCENT, CH_ZERO, 21'h144,
			CH_PERCENT, 21'h134, 21'h131};
		send_form(chars);
		// truncated escape flushes the held CR
		chars = '{CH_PERCENT, CH_ZERO, CH_UP_D, CH_PERCENT};
		send_form(chars);
		// held CR dropped at end of form
		chars = '{CH_PERCENT, CH_ZERO, CH_LO_D};
		send_form(chars);
		wait_idle();
	endtask

	task automatic test_output_limit();
		logic [CHAR_W-1:0] chars[$];
		write_limit(16'd1);
		chars = '{CH_PERCENT, "4", "1", "b", "c"};
		send_form(chars);
		// CR fits at the limit, LF does not
		write_limit(16'd3);
		chars = '{"x", "y", CH_PERCENT, CH_ZERO, CH_UP_A, "z"};
		send_form(chars);
		write_limit(16'd2);
		chars = '{"a", CH_PERCENT, CH_ZERO, CH_UP_D, CH_PLUS, "q"};
		send_form(chars);
		write_limit(LIMIT_RESET);
		chars = '{"m", CH_PLUS, CH_PERCENT, "2", "5"};
		send_form(chars);
		wait_idle();
	endtask

	task automatic test_random();
		logic [CHAR_W-1:0] chars[$];
		int start;
		int forms;
		start = items_sent;
		forms = 0;
		idle_on = 1'b1;
		while (items_sent < start + RANDOM_ITEMS) begin
			if (forms % 6 == 5) begin
				case ($urandom_range(2))
					0: write_limit(LEN_W'($urandom_range(1, 8)));
					1: write_limit(LIMIT_RESET);
					default: write_limit(LEN_W'($urandom_range(9, 200)));
				endcase
			end
			chars = {};
			repeat ($urandom_range(1, 8)) add_token(chars);
			send_form(chars);
			forms++;
			if (items_sent - start > NO_IDLE_AFTER) idle_on = 1'b0;
		end
		wait_idle();
		idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		logic [CHAR_W-1:0] chars[$];
		write_limit(LIMIT_RESET);
		chars = {};
		repeat (80) chars.push_back(CHAR_W'($urandom_range(8'h20, 8'h7E)));
		@(posedge clk);
		rx_hold = 400;
		@(negedge clk);
		send_form(chars);
		wait_idle();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_output_limit();
		test_random();
		test_backpressure();

		wait_idle();
		if (errors == 0 && expected_beats.size() == 0)
			$display("form_urlencoded_decoder: match");
		else
			$display("form_urlencoded_decoder: mismatch");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/fud_pkg.sv
hdl/form_urlencoded_decoder.sv
verif/tb_top.sv
